@@ design/blfna_pkg.sv @@
// ----------------------------------------------------------------------------
// blfna_pkg
// Shared types, constants and helper functions of the lowest-free-number
// allocator.
// ----------------------------------------------------------------------------
package blfna_pkg;

	localparam int CAPACITY  = 1024;
	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_AW    = $clog2(WORD_BITS);
	localparam int NUM_W     = 10;
	localparam int CMD_W     = 2;
	localparam int CNT_W     = 11;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(CAPACITY);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [NUM_WORDS-1:0] summary_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [NUM_W-1:0] number;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [NUM_W-1:0] granted_number;
	} rsp_t;

	// Free pattern of word w right after reset or a count write.
	function automatic word_t fill_word(input logic [WORD_AW-1:0] w,
			input logic [CNT_W-1:0] count);
		logic [CNT_W+WORD_AW:0] base;
		logic [CNT_W+WORD_AW:0] rem;
		word_t                  mask;
		base = (CNT_W + WORD_AW + 1)'(w) * (CNT_W + WORD_AW + 1)'(WORD_BITS);
		rem  = (CNT_W + WORD_AW + 1)'(count) - base;
		if ((CNT_W + WORD_AW + 1)'(count) <= base) begin
			mask = '0;
		end else if (rem >= (CNT_W + WORD_AW + 1)'(WORD_BITS)) begin
			mask = '1;
		end else begin
			mask = ~({WORD_BITS{1'b1}} << rem[BIT_AW-1:0]);
		end
		return mask;
	endfunction

	// Index of the lowest set bit of a word; zero when none is set.
	function automatic logic [BIT_AW-1:0] lowest_bit(input word_t v);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_AW'(i);
			end
		end
		return idx;
	endfunction

	// Index of the lowest non-empty word; zero when none.
	function automatic logic [WORD_AW-1:0] lowest_word(input summary_t v);
		logic [WORD_AW-1:0] idx;
		idx = '0;
		for (int i = NUM_WORDS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = WORD_AW'(i);
			end
		end
		return idx;
	endfunction

	// Summary after reset or a count write: words below the count hold free bits.
	function automatic summary_t fill_summary(input logic [CNT_W-1:0] count);
		summary_t s;
		for (int i = 0; i < NUM_WORDS; i++) begin
			s[i] = (CNT_W + WORD_AW + 1)'(count) >
				(CNT_W + WORD_AW + 1)'(i) * (CNT_W + WORD_AW + 1)'(WORD_BITS);
		end
		return s;
	endfunction

endpackage

@@ design/bitmap_lowest_free_number_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_lowest_free_number_allocator
// Hands out the lowest free number from a bitmap held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; the request is taken at
// that edge. Each request has two steps: the synchronous read of the
// bitmap word, then its modify and write-back, so busy is high for exactly
// one cycle after every accepted request. The result appears on result with done
// high for one cycle, in the cycle that follows the busy cycle; it cannot be
// held off: the receiver must take it then. A new request may be started in the
// cycle the previous result is shown. The lowest non-empty word is found
// from a 32-bit summary register kept beside the RAM, so allocate costs the
// same as check or release. Write max_numbers (cfg_we, cfg_wdata) only while
// no request is in flight; values above the capacity saturate, and every
// number below the count becomes free at once, with no clearing pass:
// per-word valid bits make a word that has not been written since read as
// its fresh free pattern.
// ----------------------------------------------------------------------------
module bitmap_lowest_free_number_allocator import blfna_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             request,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             result
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_MOD  = 1'b1;

	logic state_q;

	// Bitmap storage: one word per 32 numbers, set bit means free.
	word_t free_mem [NUM_WORDS];
	word_t rdata_s1;

	logic [NUM_WORDS-1:0] valid_q;    // word written since last fill
	summary_t             summary_q;  // word holds at least one free bit
	logic [CNT_W-1:0]     count_q;    // effective count, saturated

	logic [CMD_W-1:0]   cmd_s1;
	logic [WORD_AW-1:0] addr_s1;
	logic [BIT_AW-1:0]  bit_s1;
	logic               hit_s1;      // alloc: a word is free; else: in range

	rsp_t result_q;
	logic done_q;

	logic               accept;
	logic [WORD_AW-1:0] rd_addr;
	logic [CNT_W-1:0]   cfg_count;
	word_t              cur_word;
	logic [BIT_AW-1:0]  alloc_bit;
	logic [BIT_AW-1:0]  use_bit;
	word_t              new_word;
	logic               wr_en;
	rsp_t               rsp_d;

	assign accept    = start && !busy;
	assign busy      = (state_q == S_MOD);
	assign cfg_count = (cfg_wdata > CNT_RESET) ? CNT_RESET : cfg_wdata;

	// Allocate reads the lowest non-empty word; check and release read the
	// word that holds the number.
	assign rd_addr = (request.cmd == CMD_ALLOC) ? lowest_word(summary_q)
		: WORD_AW'(request.number >> BIT_AW);

	// Modify stage: merge the read word with its fill pattern and edit it.
	always_comb begin
		cur_word  = valid_q[addr_s1] ? rdata_s1 : fill_word(addr_s1, count_q);
		alloc_bit = lowest_bit(cur_word);
		use_bit   = (cmd_s1 == CMD_ALLOC) ? alloc_bit : bit_s1;
		new_word  = cur_word;
		wr_en     = 1'b0;
		rsp_d     = '0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (hit_s1) begin
					new_word[alloc_bit]  = 1'b0;
					wr_en                = 1'b1;
					rsp_d.ok             = 1'b1;
					rsp_d.granted_number = NUM_W'({addr_s1, alloc_bit});
				end
			end
			CMD_CHECK: begin
				rsp_d.ok = hit_s1 && cur_word[bit_s1];
			end
			CMD_RELEASE: begin
				if (hit_s1) begin
					new_word[bit_s1] = 1'b1;
					wr_en            = 1'b1;
					rsp_d.ok         = 1'b1;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// RAM: read at acceptance, write back at the end of the modify stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= free_mem[rd_addr];
		end
		if (busy && wr_en) begin
			free_mem[addr_s1] <= new_word;
		end
	end

	// Request capture; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= request.cmd;
			bit_s1  <= request.number[BIT_AW-1:0];
			addr_s1 <= rd_addr;
			if (request.cmd == CMD_ALLOC) begin
				hit_s1 <= |summary_q;
			end else begin
				hit_s1 <= {1'b0, request.number} < count_q;
			end
		end
		if (busy) begin
			result_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			valid_q   <= '0;
			summary_q <= fill_summary(CNT_RESET);
			count_q   <= CNT_RESET;
		end else begin
			done_q <= busy;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				// drop all written words; they read as the new fill pattern
				count_q   <= cfg_count;
				valid_q   <= '0;
				summary_q <= fill_summary(cfg_count);
			end else if (busy && wr_en) begin
				valid_q[addr_s1]   <= 1'b1;
				summary_q[addr_s1] <= |new_word;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// An accepted request occupies exactly one busy cycle.
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 !busy)
		else $error("busy did not last exactly one cycle");

	// A result follows every modify cycle.
	a_done_follow: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("result strobe missing after modify stage");

	// A non-zero number is only shown with ok.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.granted_number != '0) |-> result.ok)
		else $error("granted number without ok");

	// A granted number lies below the count.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy && (cmd_s1 == CMD_ALLOC) && hit_s1 |->
			({1'b0, rsp_d.granted_number} < count_q))
		else $error("granted number at or above the count");

endmodule

@@ verif/bitmap_lowest_free_number_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_lowest_free_number_allocator_tb
// Self-checking bench for the lowest-free-number allocator. A directed
// opening covers the edge counts and commands. Randomised phases follow, each
// under its own max_numbers setting and one of three sender gap rates. A behavioural bitmap
// predicts every response, and a monitor compares each response field by
// field.
// ----------------------------------------------------------------------------
module bitmap_lowest_free_number_allocator_tb;
	import blfna_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
	localparam int unsigned      CYCLE_LIMIT = 300000;
	localparam int               PHASES      = 8;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	req_t             request   = '0;
	logic             busy;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             done;
	rsp_t             result;

	// Requests still to be driven, and responses owed by the allocator.
	req_t        pending_requests [$];
	rsp_t        owed_responses   [$];
	int unsigned issued_total   = 0;
	int unsigned accepted_total = 0;
	int unsigned mismatches     = 0;
	int unsigned cycle_count    = 0;
	int unsigned gap_pct        = 27;

	// Shadow of the free bitmap: a set bit means the number is free.
	word_t       free_words [NUM_WORDS];
	int unsigned live_count;

	bitmap_lowest_free_number_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Saturate the count at the capacity, free every number below it and clear
	// everything above, so the tail of the last used word never gets granted.
	function automatic void load_count(input logic [CNT_W-1:0] value);
		int unsigned n;
		n = (value > CAPACITY) ? CAPACITY : value;
		live_count = n;
		for (int w = 0; w < NUM_WORDS; w++) begin
			for (int b = 0; b < WORD_BITS; b++) begin
				free_words[w][b] = (w * WORD_BITS + b < n);
			end
		end
	endfunction

	// Work out the response to one request and update the shadow bitmap.
	// Allocate takes the globally lowest free number; check and release touch
	// only numbers below the live count; the unused code does nothing.
	function automatic rsp_t allocator_response(input req_t rq);
		rsp_t        r;
		int unsigned w;
		int unsigned b;
		r = '0;
		case (rq.cmd)
			CMD_ALLOC: begin
				for (int i = 0; i < live_count; i++) begin
					if (!r.ok && free_words[i / WORD_BITS][i % WORD_BITS]) begin
						free_words[i / WORD_BITS][i % WORD_BITS] = 1'b0;
						r.ok             = 1'b1;
						r.granted_number = NUM_W'(i);
					end
				end
			end
			CMD_CHECK, CMD_RELEASE: begin
				if (rq.number < live_count) begin
					w = rq.number / WORD_BITS;
					b = rq.number % WORD_BITS;
					if (rq.cmd == CMD_CHECK) begin
						r.ok = free_words[w][b];
					end else begin
						// Releasing a number that is already free is still accepted.
						free_words[w][b] = 1'b1;
						r.ok             = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Driver: take the request at the edge where start meets a low busy, then
	// either present the next pending request or drop start for a gap cycle.
	// Hold start and the request steady while busy is high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				owed_responses.push_back(allocator_response(request));
				accepted_total++;
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
					start   <= 1'b1;
					request <= pending_requests.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: a response is shown for one cycle only, so take it whenever done
	// is high and match it against the oldest owed response.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (owed_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: response with none owed: ok=%0b granted=%0d",
						$realtime, result.ok, result.granted_number);
				end
			end else begin
				want = owed_responses.pop_front();
				if (result.ok !== want.ok ||
						result.granted_number !== want.granted_number) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: ok exp %0b got %0b, granted exp %0d got %0d",
							$realtime, want.ok, result.ok,
							want.granted_number, result.granted_number);
					end
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic post(input logic [CMD_W-1:0] c, input int unsigned n);
		req_t rq;
		rq.cmd    = c;
		rq.number = NUM_W'(n);
		pending_requests.push_back(rq);
		issued_total++;
	endtask

	// Wait until every request has been taken and answered, then let the
	// pipeline drain for the given tail.
	task automatic drain(input int unsigned tail);
		while (accepted_total != issued_total || owed_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (tail) @(posedge clk);
	endtask

	// Write max_numbers only once the allocator is idle.
	task automatic write_count(input logic [CNT_W-1:0] value);
		drain(4);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_count(value);
	endtask

	// Pick a number for check or release: mostly in range and low, where the
	// grants cluster, sometimes at the range edges, sometimes anything at all.
	function automatic int unsigned pick_number();
		int unsigned hi;
		int unsigned edge_pick;
		hi = (live_count == 0) ? 0 : live_count - 1;
		case ($urandom_range(9))
			0: return $urandom_range(1023);
			1: begin
				edge_pick = $urandom_range(3);
				if (edge_pick == 0) return 0;
				if (edge_pick == 1) return hi;
				if (edge_pick == 2) return (live_count > 1023) ? 1023 : live_count;
				return 1023;
			end
			default: begin
				if ($urandom_range(1) == 1 && hi > 47) hi = 47;
				return $urandom_range(hi, 0);
			end
		endcase
	endfunction

	task automatic post_random(input int unsigned count, input int unsigned alloc_pct);
		int unsigned roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < alloc_pct) begin
				// The number field is ignored on allocate: fill it with noise.
				post(CMD_ALLOC, $urandom_range(1023));
			end else begin
				roll = $urandom_range(9);
				if (roll < 5) begin
					post(CMD_RELEASE, pick_number());
				end else if (roll < 9) begin
					post(CMD_CHECK, pick_number());
				end else begin
					post(CMD_UNUSED, $urandom_range(1023));
				end
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] counts [PHASES];
		int unsigned      alloc_pct;

		counts = '{11'd64, 11'd1024, 11'd3, 11'd2047, 11'd33, 11'd0, 11'd1000,
			CNT_W'($urandom_range(1024, 1))};
		load_count(CNT_RESET);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset count: first grants, both ends of the range, release of a free
		// number and the unused command code.
		post(CMD_ALLOC, 1023);
		post(CMD_ALLOC, 0);
		post(CMD_CHECK, 0);
		post(CMD_CHECK, 1023);
		post(CMD_RELEASE, 1023);
		post(CMD_RELEASE, 0);
		post(CMD_ALLOC, 0);
		post(CMD_UNUSED, 1023);

		// A single number: exhaust it, probe out of range, give it back.
		write_count(11'd1);
		post(CMD_ALLOC, 0);
		post(CMD_ALLOC, 0);
		post(CMD_CHECK, 0);
		post(CMD_CHECK, 1);
		post(CMD_RELEASE, 1);
		post(CMD_RELEASE, 0);
		post(CMD_ALLOC, 0);

		// No numbers at all: everything fails.
		write_count(11'd0);
		post(CMD_ALLOC, 0);
		post(CMD_CHECK, 0);
		post(CMD_RELEASE, 0);

		// Count above the capacity saturates, so the top number exists.
		write_count(11'd2047);
		post(CMD_RELEASE, 1023);
		post(CMD_CHECK, 1023);

		// Random phases: gaps at 27 in a hundred, then 52, then none.
		for (int p = 0; p < PHASES; p++) begin
			write_count(counts[p]);
			gap_pct   = (p < 3) ? 27 : (p < 6) ? 52 : 0;
			alloc_pct = (counts[p] >= 1000) ? 75 : $urandom_range(70, 35);
			post_random((counts[p] == 0) ? 40 : 200, alloc_pct);
		end

		drain(10);
		if (mismatches == 0 && owed_responses.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
